FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

FILE: rtl/core/ftb_pkg.sv
// ----------------------------------------------------------------------------
// ftb_pkg
// Types, constants and address functions of the two-electron matrix build.
// ----------------------------------------------------------------------------
`default_nettype none

package ftb_pkg;

   localparam int DIM       = 4;
   localparam int IDX_W     = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int CNT_W     = $clog2(DIM + 1);
   localparam int INT_DEPTH = DIM * DIM * DIM * DIM;
   localparam int DEN_DEPTH = DIM * DIM;
   localparam int INT_AW    = (INT_DEPTH > 1) ? $clog2(INT_DEPTH) : 1;
   localparam int DEN_AW    = (DEN_DEPTH > 1) ? $clog2(DEN_DEPTH) : 1;
   localparam int CSR_AW    = 3;

   localparam logic [1:0] OP_INTEGRAL = 2'd0;
   localparam logic [1:0] OP_DENSITY  = 2'd1;
   localparam logic [1:0] OP_COMPUTE  = 2'd2;

   localparam logic [CSR_AW-1:0] ADDR_ORBITALS  = 3'd0;
   localparam logic [2:0]        ORBITALS_RESET = 3'd4;

   localparam logic signed [63:0] ELEM_MAX = 64'sd140737488355327;
   localparam logic signed [63:0] ELEM_MIN = -64'sd140737488355328;
   localparam logic signed [63:0] ROUND_HALF = 64'sd128;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic             first;
      logic             last_term;
      logic             last_elem;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } tag_type;

   function automatic logic [INT_AW-1:0] int_addr(input logic [IDX_W-1:0] i,
                                                  input logic [IDX_W-1:0] j,
                                                  input logic [IDX_W-1:0] k,
                                                  input logic [IDX_W-1:0] l);
      return INT_AW'(((int'(i) * DIM + int'(j)) * DIM + int'(k)) * DIM + int'(l));
   endfunction

   function automatic logic [DEN_AW-1:0] den_addr(input logic [IDX_W-1:0] k,
                                                  input logic [IDX_W-1:0] l);
      return DEN_AW'(int'(k) * DIM + int'(l));
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/fock_two_electron_build.sv
// Load requests are accepted again in the next cycle.
// A compute request issues one multiply-accumulate term per cycle unless the output
// stalls, n^4 terms for n orbitals, limited by the integral memory's two read ports.
// Elements leave via the read, product, difference, accumulator and output registers.
// Reset clears the control state and sets the orbital count to four;
// the integral and density memories keep their contents.
// ----------------------------------------------------------------------------
// fock_two_electron_build
// Loads integrals and density elements into memories and streams the
// two-electron matrix through a pipelined multiply-accumulate datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module fock_two_electron_build (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  wire  [1:0]                req_op,
   input  wire  [7:0]                req_address,
   input  wire  signed [31:0]        req_value,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output logic [1:0]                rsp_row,
   output logic [1:0]                rsp_col,
   output logic signed [47:0]        rsp_element,
   output logic                      rsp_last,
   input  wire                       csr_psel,
   input  wire                       csr_penable,
   input  wire                       csr_pwrite,
   input  wire  [ftb_pkg::CSR_AW-1:0] csr_paddr,
   input  wire  [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

`include "assert_macros.svh"

   localparam int IW = ftb_pkg::IDX_W;

   ftb_pkg::state_type state_ff, state_in;

   logic [2:0]          orbitals_ff;
   logic [IW-1:0]       nl_ff, nl_in;
   logic [IW-1:0]       i_ff, j_ff, k_ff, l_ff;
   logic [IW-1:0]       i_in, j_in, k_in, l_in;

   logic                issue_active;
   logic                adv;
   logic                req_fire;
   logic                start;
   logic                iss_first, iss_last_term, iss_last_elem;
   logic [ftb_pkg::CNT_W-1:0] n_cnt;

   logic [31:0] int_mem [ftb_pkg::INT_DEPTH];
   logic [31:0] den_mem [ftb_pkg::DEN_DEPTH];

   logic signed [31:0]  p_ff, a_ff, b_ff;
   logic signed [63:0]  pa_ff, pb_ff, d_ff, acc_ff;
   logic signed [63:0]  pa_in, pb_in, d_in, acc_in, term, rnd;
   logic                v1_ff, v2_ff, v3_ff, done_ff;
   ftb_pkg::tag_type    tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag0;

   logic                rsp_valid_ff;
   logic [1:0]          rsp_row_ff, rsp_col_ff;
   logic signed [47:0]  rsp_element_ff, elem_in;
   logic                rsp_last_ff;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ftb_pkg::ADDR_ORBITALS) ? 32'(orbitals_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         orbitals_ff <= ftb_pkg::ORBITALS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr == ftb_pkg::ADDR_ORBITALS) begin
         orbitals_ff <= csr_pwdata[2:0];
      end
   end

   assign n_cnt = (int'(orbitals_ff) > ftb_pkg::DIM) ? ftb_pkg::CNT_W'(ftb_pkg::DIM)
                                                     : ftb_pkg::CNT_W'(orbitals_ff);
   assign req_fire = req_valid && req_ready;
   assign start    = req_fire && req_op == ftb_pkg::OP_COMPUTE && n_cnt != '0;

   // The pipeline stalls only when a finished element cannot enter the output register.
   assign adv = !(done_ff && rsp_valid_ff && !rsp_ready);

   assign iss_first     = (k_ff == '0) && (l_ff == '0);
   assign iss_last_term = (k_ff == nl_ff) && (l_ff == nl_ff);
   assign iss_last_elem = (i_ff == nl_ff) && (j_ff == nl_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ftb_pkg::ST_IDLE: begin
            if (start) state_in = ftb_pkg::ST_RUN;
         end
         ftb_pkg::ST_RUN: begin
            if (adv && iss_last_term && iss_last_elem) state_in = ftb_pkg::ST_DRAIN;
         end
         ftb_pkg::ST_DRAIN: begin
            if (!v1_ff && !v2_ff && !v3_ff && !done_ff) state_in = ftb_pkg::ST_IDLE;
         end
         default: state_in = ftb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      issue_active = 1'b0;
      case (state_ff)
         ftb_pkg::ST_IDLE:  req_ready    = 1'b1;
         ftb_pkg::ST_RUN:   issue_active = 1'b1;
         ftb_pkg::ST_DRAIN: ;
         default: ;
      endcase
   end

   always_comb begin
      i_in  = i_ff;
      j_in  = j_ff;
      k_in  = k_ff;
      l_in  = l_ff;
      nl_in = nl_ff;
      if (start) begin
         i_in  = '0;
         j_in  = '0;
         k_in  = '0;
         l_in  = '0;
         nl_in = IW'(n_cnt - 1'b1);
      end else if (issue_active && adv) begin
         if (l_ff != nl_ff) begin
            l_in = l_ff + 1'b1;
         end else begin
            l_in = '0;
            if (k_ff != nl_ff) begin
               k_in = k_ff + 1'b1;
            end else begin
               k_in = '0;
               if (j_ff != nl_ff) begin
                  j_in = j_ff + 1'b1;
               end else begin
                  j_in = '0;
                  i_in = i_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ftb_pkg::ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         l_ff     <= '0;
         nl_ff    <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         l_ff     <= l_in;
         nl_ff    <= nl_in;
      end
   end

   // Memories: one write port, registered reads.
   always_ff @(posedge clock) begin
      if (req_fire && req_op == ftb_pkg::OP_INTEGRAL
          && int'(req_address) < ftb_pkg::INT_DEPTH) begin
         int_mem[ftb_pkg::INT_AW'(req_address)] <= req_value;
      end
      if (adv) begin
         a_ff <= int_mem[ftb_pkg::int_addr(i_ff, j_ff, k_ff, l_ff)];
         b_ff <= int_mem[ftb_pkg::int_addr(i_ff, l_ff, k_ff, j_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_op == ftb_pkg::OP_DENSITY
          && int'(req_address) < ftb_pkg::DEN_DEPTH) begin
         den_mem[ftb_pkg::DEN_AW'(req_address)] <= req_value;
      end
      if (adv) begin
         p_ff <= den_mem[ftb_pkg::den_addr(k_ff, l_ff)];
      end
   end

   // Datapath.
   always_comb begin
      tag0.first     = iss_first;
      tag0.last_term = iss_last_term;
      tag0.last_elem = iss_last_elem;
      tag0.row       = i_ff;
      tag0.col       = j_ff;
      pa_in  = p_ff * a_ff;
      pb_in  = p_ff * b_ff;
      d_in   = pa_ff - (pb_ff >>> 1);
      term   = d_ff >>> 16;
      acc_in = tag3_ff.first ? term : acc_ff + term;
      rnd    = (acc_ff + ftb_pkg::ROUND_HALF) >>> 8;
      if (rnd > ftb_pkg::ELEM_MAX) begin
         elem_in = ftb_pkg::ELEM_MAX[47:0];
      end else if (rnd < ftb_pkg::ELEM_MIN) begin
         elem_in = ftb_pkg::ELEM_MIN[47:0];
      end else begin
         elem_in = rnd[47:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag1_ff <= tag0;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         pa_ff   <= pa_in;
         pb_ff   <= pb_in;
         d_ff    <= d_in;
         if (v3_ff) acc_ff <= acc_in;
         if (v3_ff && tag3_ff.last_term) tag4_ff <= tag3_ff;
      end
      if (adv && done_ff) begin
         rsp_row_ff     <= 2'(tag4_ff.row);
         rsp_col_ff     <= 2'(tag4_ff.col);
         rsp_element_ff <= elem_in;
         rsp_last_ff    <= tag4_ff.last_elem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            v1_ff   <= issue_active;
            v2_ff   <= v1_ff;
            v3_ff   <= v2_ff;
            done_ff <= v3_ff && tag3_ff.last_term;
         end
         if (adv && done_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_row     = rsp_row_ff;
   assign rsp_col     = rsp_col_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_last    = rsp_last_ff;

   `ASSERT_IMP(a_idle_empty, clock, reset, req_ready, !v1_ff && !v2_ff && !v3_ff && !done_ff)
   `ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_element))
   `ASSERT_IMP(a_counters_bound, clock, reset, state_ff == ftb_pkg::ST_RUN, i_ff <= nl_ff && j_ff <= nl_ff && k_ff <= nl_ff && l_ff <= nl_ff)
   `ASSERT_NXT(a_stall_holds, clock, reset, done_ff && rsp_valid && !rsp_ready, done_ff && $stable(acc_ff))

endmodule

`default_nettype wire
